/* hdl/bpa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_pkg: shared types and constants for the bitmap page allocator
// Request and status codes, field widths of the stream payloads.
// ----------------------------------------------------------------------------

package bpa_pkg;

  // Payload field widths
  localparam int REQ_W    = 2;
  localparam int INDEX_W  = 12;
  localparam int COUNT_W  = 13;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 13;

  // Internal block position: holds index + count and a word base past the end
  localparam int POS_W = 14;

  // Stream data widths, padded to whole bytes
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_FREE    = 2'd1,
    REQ_RESERVE = 2'd2,
    REQ_RELEASE = 2'd3
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 2'd0,
    STS_OOM   = 2'd1,
    STS_RANGE = 2'd2
  } status_e;

endpackage

/* hdl/bitmap_page_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_page_allocator: one-bit-per-block allocator
// Usage bitmap in a synchronous memory, swept one word per cycle.
// ----------------------------------------------------------------------------
// The usage bitmap (a set bit marks a used block) lives in one single-port-
// write, one-read memory of WORD_BITS-bit words. Every request that is not
// answered at once sweeps that memory from word 0 with a read-modify-write
// pipeline: one word is read per cycle while the previous word is masked,
// updated and written back. Allocate stops at the first word holding a clear
// bit below total_blocks; free, reserve and release run up to the word holding
// the last block of their range. Requests whose answer is known at once (index
// or range out of bounds, empty range, zero total) skip the sweep. After reset
// the block runs a clearing pass that writes every word to all ones; s_axis
// tready stays low during it. One request is in work at a time; a finished
// result waits in the output register while the next request is accepted.
// total_blocks is written through cfg_we_i / cfg_wdata_i; the user must write
// it only while idle, the block itself does not enforce it.

module bitmap_page_allocator #(
  parameter int NUM_BLOCKS = 4096,
  parameter int WORD_BITS  = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // total_blocks register
  input  logic                          cfg_we_i,
  input  logic [bpa_pkg::TOTAL_W-1:0]   cfg_wdata_i,
  // request stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [11:0] block_index, [24:12] block_count, [31:25] zero
  input  logic [bpa_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // [1:0] req_type
  input  logic [bpa_pkg::REQ_W-1:0]     s_axis_tuser,
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [11:0] alloc_block, [24:12] free_blocks, [31:25] zero
  output logic [bpa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // [1:0] status
  output logic [bpa_pkg::STATUS_W-1:0]  m_axis_tuser
);

  localparam int MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int PW        = $clog2(WORD_BITS);
  localparam int CW        = $clog2(WORD_BITS + 1);
  localparam int PAD_W     = bpa_pkg::OUT_DATA_W - bpa_pkg::TOTAL_W - bpa_pkg::INDEX_W;

  localparam logic [AW-1:0]                 LAST_WORD = AW'(MAP_WORDS - 1);
  localparam logic [bpa_pkg::POS_W-1:0]     WORD_STEP = bpa_pkg::POS_W'(WORD_BITS);
  localparam logic [WORD_BITS-1:0]          FULL_WORD = '1;

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  // Control and datapath registers
  state_e                        state_q, state_d;
  logic [bpa_pkg::TOTAL_W-1:0]   total_q, total_d;
  logic [bpa_pkg::TOTAL_W-1:0]   fc_q, fc_d;
  bpa_pkg::req_e                 req_q, req_d;
  logic [bpa_pkg::POS_W-1:0]     lo_q, lo_d;
  logic [bpa_pkg::POS_W-1:0]     hi_q, hi_d;
  logic [AW-1:0]                 rd_addr_q, rd_addr_d;
  logic [bpa_pkg::POS_W-1:0]     rd_base_q, rd_base_d;
  logic                          rvalid_q, rvalid_d;
  logic [AW-1:0]                 pw_addr_q, pw_addr_d;
  logic [bpa_pkg::POS_W-1:0]     pbase_q, pbase_d;
  logic [AW-1:0]                 clr_q, clr_d;
  bpa_pkg::status_e              res_status_q, res_status_d;
  logic [bpa_pkg::INDEX_W-1:0]   res_alloc_q, res_alloc_d;
  logic                          out_valid_q, out_valid_d;
  bpa_pkg::status_e              out_status_q, out_status_d;
  logic [bpa_pkg::INDEX_W-1:0]   out_alloc_q, out_alloc_d;
  logic [bpa_pkg::TOTAL_W-1:0]   out_free_q, out_free_d;

  // Bitmap memory
  logic [WORD_BITS-1:0]          bitmap_mem [MAP_WORDS];
  logic [WORD_BITS-1:0]          rdata_q;
  logic                          mem_re;
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [WORD_BITS-1:0]          mem_wdata;

  // Request fields
  logic [bpa_pkg::INDEX_W-1:0]   in_idx;
  logic [bpa_pkg::COUNT_W-1:0]   in_cnt;
  bpa_pkg::req_e                 in_req;
  logic                          in_acc;
  logic                          out_free_slot;

  // Word processing
  logic [bpa_pkg::TOTAL_W-1:0]   eff_total;
  logic [bpa_pkg::POS_W-1:0]     in_hi;
  logic [bpa_pkg::POS_W-1:0]     bit_pos;
  logic [WORD_BITS-1:0]          word_mask;
  logic [WORD_BITS-1:0]          cand;
  logic [PW-1:0]                 first_free;
  logic [CW-1:0]                 changed;
  logic                          last_word;

  assign in_idx = s_axis_tdata[bpa_pkg::INDEX_W-1:0];
  assign in_cnt = s_axis_tdata[bpa_pkg::INDEX_W +: bpa_pkg::COUNT_W];
  assign in_req = bpa_pkg::req_e'(s_axis_tuser);

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free_slot = !out_valid_q || m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {PAD_W'(0), out_free_q, out_alloc_q};

  // A total above the map acts as the map size
  always_comb begin
    if (int'(total_q) > NUM_BLOCKS) begin
      eff_total = bpa_pkg::TOTAL_W'(NUM_BLOCKS);
    end else begin
      eff_total = total_q;
    end
  end

  // Upper bound (exclusive) of the requested range
  always_comb begin
    case (in_req)
      bpa_pkg::REQ_ALLOC: begin
        in_hi = bpa_pkg::POS_W'(eff_total);
      end
      bpa_pkg::REQ_FREE: begin
        in_hi = bpa_pkg::POS_W'(in_idx) + bpa_pkg::POS_W'(1);
      end
      default: begin
        in_hi = bpa_pkg::POS_W'(in_idx) + bpa_pkg::POS_W'(in_cnt);
      end
    endcase
  end

  // Bits of the word in work that fall inside [lo, hi)
  always_comb begin
    word_mask = '0;
    bit_pos   = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      bit_pos      = pbase_q + bpa_pkg::POS_W'(j);
      word_mask[j] = (bit_pos >= lo_q) && (bit_pos < hi_q);
    end
  end

  // Lowest free block of the word for allocate
  assign cand = ~rdata_q & word_mask;

  always_comb begin
    first_free = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (cand[j]) begin
        first_free = PW'(j);
      end
    end
  end

  always_comb begin
    if (req_q == bpa_pkg::REQ_RELEASE || req_q == bpa_pkg::REQ_FREE) begin
      changed = CW'($countones(word_mask & rdata_q));
    end else begin
      changed = CW'($countones(word_mask & ~rdata_q));
    end
  end

  assign last_word = (pbase_q + WORD_STEP) >= hi_q;

  // Next-state logic
  always_comb begin
    state_d      = state_q;
    total_d      = total_q;
    fc_d         = fc_q;
    req_d        = req_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    rd_addr_d    = rd_addr_q;
    rd_base_d    = rd_base_q;
    rvalid_d     = 1'b0;
    pw_addr_d    = pw_addr_q;
    pbase_d      = pbase_q;
    clr_d        = clr_q;
    res_status_d = res_status_q;
    res_alloc_d  = res_alloc_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_alloc_d  = out_alloc_q;
    out_free_d   = out_free_q;
    mem_re       = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = pw_addr_q;
    mem_wdata    = rdata_q;

    if (cfg_we_i) begin
      total_d = cfg_wdata_i;
    end

    // Drop the output once the consumer takes it
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_INIT: begin
        // Mark every block used, one word a cycle
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = FULL_WORD;
        clr_d     = clr_q + AW'(1);
        if (clr_q == LAST_WORD) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          req_d        = in_req;
          hi_d         = in_hi;
          lo_d         = (in_req == bpa_pkg::REQ_ALLOC) ? '0 : bpa_pkg::POS_W'(in_idx);
          rd_addr_d    = '0;
          rd_base_d    = '0;
          res_status_d = bpa_pkg::STS_OK;
          res_alloc_d  = '0;
          state_d      = S_SCAN;
          if (in_req == bpa_pkg::REQ_ALLOC) begin
            if (eff_total == '0) begin
              res_status_d = bpa_pkg::STS_OOM;
              state_d      = S_DONE;
            end
          end else if ((bpa_pkg::TOTAL_W'(in_idx) >= eff_total) ||
                       (in_hi > bpa_pkg::POS_W'(eff_total))) begin
            res_status_d = bpa_pkg::STS_RANGE;
            state_d      = S_DONE;
          end else if (in_req != bpa_pkg::REQ_FREE && in_cnt == '0) begin
            state_d = S_DONE;
          end
        end
      end

      S_SCAN: begin
        // Issue the read of the next word while the current one is updated
        if (rd_base_q < hi_q) begin
          mem_re    = 1'b1;
          rvalid_d  = 1'b1;
          pw_addr_d = rd_addr_q;
          pbase_d   = rd_base_q;
          rd_addr_d = rd_addr_q + AW'(1);
          rd_base_d = rd_base_q + WORD_STEP;
        end

        if (rvalid_q) begin
          case (req_q)
            bpa_pkg::REQ_ALLOC: begin
              if (cand != '0) begin
                mem_we      = 1'b1;
                mem_wdata   = rdata_q | (WORD_BITS'(1) << first_free);
                fc_d        = fc_q - bpa_pkg::TOTAL_W'(1);
                res_alloc_d = bpa_pkg::INDEX_W'(pbase_q + bpa_pkg::POS_W'(first_free));
                rvalid_d    = 1'b0;
                state_d     = S_DONE;
              end else if (last_word) begin
                res_status_d = bpa_pkg::STS_OOM;
                rvalid_d     = 1'b0;
                state_d      = S_DONE;
              end
            end
            bpa_pkg::REQ_RESERVE: begin
              mem_we    = 1'b1;
              mem_wdata = rdata_q | word_mask;
              fc_d      = fc_q - bpa_pkg::TOTAL_W'(changed);
            end
            default: begin
              mem_we    = 1'b1;
              mem_wdata = rdata_q & ~word_mask;
              fc_d      = fc_q + bpa_pkg::TOTAL_W'(changed);
            end
          endcase
          if (req_q != bpa_pkg::REQ_ALLOC && last_word) begin
            rvalid_d = 1'b0;
            state_d  = S_DONE;
          end
        end
      end

      S_DONE: begin
        // Hold the result until the output register is free
        if (out_free_slot) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_alloc_d  = res_alloc_q;
          out_free_d   = fc_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      total_q     <= bpa_pkg::TOTAL_W'(4096);
      fc_q        <= '0;
      clr_q       <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      fc_q        <= fc_d;
      clr_q       <= clr_d;
      rvalid_q    <= rvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    rd_addr_q    <= rd_addr_d;
    rd_base_q    <= rd_base_d;
    pw_addr_q    <= pw_addr_d;
    pbase_q      <= pbase_d;
    res_status_q <= res_status_d;
    res_alloc_q  <= res_alloc_d;
    out_status_q <= out_status_d;
    out_alloc_q  <= out_alloc_d;
    out_free_q   <= out_free_d;
  end

  // Bitmap memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bitmap_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= bitmap_mem[rd_addr_q];
    end
  end

endmodule

/* hdl/bpa_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_checker: port-level checks for the bitmap page allocator
// Watches the stream ports over time; bound to the top level below.
// ----------------------------------------------------------------------------

module bpa_checker #(
  parameter int NUM_BLOCKS = 4096
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [bpa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [bpa_pkg::STATUS_W-1:0]   m_axis_tuser
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // A failed request gives no block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != bpa_pkg::STS_OK |->
      m_axis_tdata[bpa_pkg::INDEX_W-1:0] == '0)
    else $error("failed request returned a block");

  // The free count never exceeds the map
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      int'(m_axis_tdata[bpa_pkg::INDEX_W +: bpa_pkg::TOTAL_W]) <= NUM_BLOCKS)
    else $error("free count above map size");

  // No request is taken in the first cycle after reset: the clearing pass runs
  assert property (@(posedge clk_i)
    rst_ni && !$past(rst_ni) |-> !s_axis_tready)
    else $error("request taken during clearing pass");

endmodule

bind bitmap_page_allocator bpa_checker #(
  .NUM_BLOCKS(NUM_BLOCKS)
) u_bpa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
